// ===== src/etrc_pkg.sv =====
package etrc_pkg;

  localparam int HIST_DEPTH  = 22;
  localparam int WIN_LEN     = HIST_DEPTH + 1;
  localparam int WIN_BITS    = 8 * WIN_LEN;
  localparam int NUM_FATAL   = 3;
  localparam int NUM_PHRASES = 29;

  // verdict source codes
  typedef enum logic [1:0] {
    DEC_STATUS = 2'd0,
    DEC_FATAL  = 2'd1,
    DEC_RETRY  = 2'd2,
    DEC_NONE   = 2'd3
  } decided_t;

  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctrl_t;

  typedef struct packed {
    logic fatal;
    logic retry;
  } match_t;

  // phrases right-aligned, last byte in bits [7:0]; fatal phrases first
  localparam logic [WIN_BITS-1:0] PHRASE_TXT [NUM_PHRASES] = '{
    {"context_", "overflow"}, "context too long", "maximum context length",
    "429", "500", "502", "503", "504", "524",
    "rate limit", {"rate_", "limit"}, "ratelimit",
    "overloaded", {"server_", "error"}, {"internal_", "error"},
    "fetch failed", {"fetch_", "error"}, {"network_", "error"},
    "timeout", "timed out", {"connection_", "error"},
    "connection reset", "connection refused",
    "eof", "econnreset", "enotfound",
    "temporarily unavailable", "try again",
    "service unavailable"
  };

  localparam int PHRASE_LEN [NUM_PHRASES] = '{
    16, 16, 22,
    3, 3, 3, 3, 3, 3,
    10, 10, 9,
    10, 12, 14,
    12, 11, 13,
    7, 9, 16,
    16, 18,
    3, 10, 9,
    23, 9,
    19
  };

  localparam logic [9:0] ST_400 = 10'd400;
  localparam logic [9:0] ST_401 = 10'd401;
  localparam logic [9:0] ST_403 = 10'd403;
  localparam logic [9:0] ST_404 = 10'd404;
  localparam logic [9:0] ST_429 = 10'd429;
  localparam logic [9:0] ST_500 = 10'd500;
  localparam logic [9:0] ST_502 = 10'd502;
  localparam logic [9:0] ST_503 = 10'd503;
  localparam logic [9:0] ST_504 = 10'd504;
  localparam logic [9:0] ST_524 = 10'd524;

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= 8'h41 && c <= 8'h5a) begin
      r = c + 8'h20;
    end
    return r;
  endfunction

  function automatic logic status_no_retry(input logic [9:0] s);
    return (s == ST_400) || (s == ST_401) || (s == ST_403) || (s == ST_404);
  endfunction

  function automatic logic status_retry(input logic [9:0] s);
    return (s == ST_429) || (s == ST_500) || (s == ST_502) || (s == ST_503) ||
           (s == ST_504) || (s == ST_524);
  endfunction

endpackage

// ===== src/etrc_cell.sv =====
module etrc_cell
  import etrc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  cell_ctrl_t ctrl,
  input  logic [7:0] d,
  output logic [7:0] q
);

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      q <= 8'd0;
    end else if (ctrl.shift) begin
      q <= d;
    end
  end

endmodule

// ===== src/etrc_matcher.sv =====
module etrc_matcher
  import etrc_pkg::*;
(
  input  logic [WIN_BITS-1:0] win,
  output match_t              hits
);

  logic [NUM_PHRASES-1:0] hit;

  for (genvar i = 0; i < NUM_PHRASES; i++) begin : g_phrase
    // only the phrase's own bytes take part
    localparam logic [WIN_BITS-1:0] MASK =
      {WIN_BITS{1'b1}} >> (WIN_BITS - 8 * PHRASE_LEN[i]);
    assign hit[i] = ((win ^ PHRASE_TXT[i]) & MASK) == '0;
  end

  assign hits.fatal = |hit[NUM_FATAL-1:0];
  assign hits.retry = |hit[NUM_PHRASES-1:NUM_FATAL];

endmodule

// ===== src/error_text_retry_classifier.sv =====
// the verdict word is registered and is valid in the cycle after the last item is accepted
// throughput: one item per cycle while input is not held off
// input is held off only while a verdict word waits and a last item arrives
// the row of 22 byte cells plus the arriving byte is matched combinationally
// reset (synchronous, active high) clears history cells, sticky flags and out_valid
module error_text_retry_classifier
  import etrc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  // input word
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] ch,
  input  logic       has_char,
  input  logic       last,
  input  logic [9:0] http_status,
  // verdict word
  output logic       out_valid,
  input  logic       out_ready,
  output logic       retryable,
  output logic [1:0] decided_by
);

  logic                accept;
  logic [7:0]          cur;
  logic [7:0]          hist [HIST_DEPTH];
  logic [WIN_BITS-1:0] win;
  cell_ctrl_t          cell_ctrl;
  match_t              hits;
  logic                saw_fatal;
  logic                saw_retry;
  logic                saw_fatal_next;
  logic                saw_retry_next;
  logic                res_retry;
  decided_t            res_by;
  logic                out_retry;
  decided_t            out_by;

  // a non-last word produces no verdict, so it can pass a waiting verdict
  assign in_ready = ~out_valid | out_ready | ~last;
  assign accept   = in_valid & in_ready;

  assign cur = to_lower(ch);

  // the row shifts toward index 0 (oldest); a last word empties it
  assign cell_ctrl.shift = accept & has_char;
  assign cell_ctrl.clear = accept & last;

  for (genvar k = 0; k < HIST_DEPTH; k++) begin : g_cell
    logic [7:0] d;
    if (k == HIST_DEPTH - 1) begin : g_head
      assign d = cur;
    end else begin : g_body
      assign d = hist[k+1];
    end
    etrc_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .ctrl (cell_ctrl),
      .d    (d),
      .q    (hist[k])
    );
  end

  // window: arriving byte in the low byte, then history newest first
  always_comb begin
    win[7:0] = cur;
    for (int j = 0; j < HIST_DEPTH; j++) begin
      win[8*(j+1) +: 8] = hist[HIST_DEPTH-1-j];
    end
  end

  etrc_matcher u_matcher (
    .win  (win),
    .hits (hits)
  );

  // sticky phrase flags including this cycle's byte
  always_comb begin
    saw_fatal_next = saw_fatal | (has_char & hits.fatal);
    saw_retry_next = saw_retry | (has_char & hits.retry);
  end

  // verdict: status rule, then fatal phrase, then retry phrase
  always_comb begin
    priority if (status_no_retry(http_status)) begin
      res_retry = 1'b0;
      res_by    = DEC_STATUS;
    end else if (status_retry(http_status)) begin
      res_retry = 1'b1;
      res_by    = DEC_STATUS;
    end else if (saw_fatal_next) begin
      res_retry = 1'b0;
      res_by    = DEC_FATAL;
    end else if (saw_retry_next) begin
      res_retry = 1'b1;
      res_by    = DEC_RETRY;
    end else begin
      res_retry = 1'b0;
      res_by    = DEC_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      saw_fatal <= 1'b0;
      saw_retry <= 1'b0;
    end else if (accept) begin
      if (last) begin
        saw_fatal <= 1'b0;
        saw_retry <= 1'b0;
      end else begin
        saw_fatal <= saw_fatal_next;
        saw_retry <= saw_retry_next;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept && last) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && last) begin
      out_retry <= res_retry;
      out_by    <= res_by;
    end
  end

  assign retryable  = out_retry;
  assign decided_by = out_by;

  // a finished message leaves no sticky flag behind
  a_flags_cleared: assert property (@(posedge clk) disable iff (rst)
    accept && last |=> !saw_fatal && !saw_retry)
    else $error("sticky flags survive end of message");

  // every accepted last word yields a verdict next cycle
  a_verdict_follows: assert property (@(posedge clk) disable iff (rst)
    accept && last |=> out_valid)
    else $error("verdict missing after last word");

  // a waiting verdict is never overwritten
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !(accept && last))
    else $error("last word accepted over pending verdict");

  // phrase verdicts carry their fixed outcome
  a_fatal_no: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_by == DEC_FATAL || out_by == DEC_NONE) |-> !out_retry)
    else $error("fatal or unmatched verdict marked retryable");

  a_retry_yes: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_by == DEC_RETRY |-> out_retry)
    else $error("retry phrase verdict not retryable");

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import etrc_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_WORDS = 1950;
  localparam int NUM_TXT = 29;
  localparam int NUM_FATAL_TXT = 3;

  // one input word as queued for the driver
  typedef struct {
    logic [7:0] ch;
    logic       has_char;
    logic       last;
    logic [9:0] status;
    logic       drain;
    int unsigned gap;
  } in_word_t;

  // one expected verdict word
  typedef struct {
    logic     retryable;
    decided_t by;
  } verdict_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] ch = 8'h00;
  logic       has_char = 1'b0;
  logic       last = 1'b0;
  logic [9:0] http_status = 10'd0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic       retryable;
  logic [1:0] decided_by;

  // phrase list, fatal phrases first
  string phrase_txt [NUM_TXT] = '{
    {string'("context_"), "overflow"}, "context too long", "maximum context length",
    "429", "500", "502", "503", "504", "524",
    "rate limit", {string'("rate_"), "limit"}, "ratelimit",
    "overloaded", {string'("server_"), "error"}, {string'("internal_"), "error"},
    "fetch failed", {string'("fetch_"), "error"}, {string'("network_"), "error"},
    "timeout", "timed out", {string'("connection_"), "error"},
    "connection reset", "connection refused",
    "eof", "econnreset", "enotfound",
    "temporarily unavailable", "try again",
    "service unavailable"
  };

  in_word_t word_q [$];      // words waiting for the driver
  verdict_t verdict_q [$];   // verdicts predicted but not yet seen
  in_word_t staged_w;
  in_word_t live_w;
  bit       staged = 1'b0;
  int unsigned gap_left = 0;
  int unsigned err_cnt = 0;
  int unsigned cycle_cnt = 0;
  int unsigned words_made = 0;
  int unsigned msg_cnt = 0;
  bit       drain_next = 1'b0;

  // sender idling: alternate between quiet stretches and random gaps
  bit       send_quiet = 1'b0;
  int unsigned send_left = 0;

  // receiver idling, same scheme
  bit       recv_quiet = 1'b0;
  int unsigned recv_left = 0;
  int unsigned stall_left = 0;

  // predictor state: history packed oldest byte in bits [7:0]
  logic [8*HIST_DEPTH-1:0] byte_hist = '0;
  bit fatal_seen = 1'b0;
  bit retry_seen = 1'b0;

  error_text_retry_classifier u_top (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .ch          (ch),
    .has_char    (has_char),
    .last        (last),
    .http_status (http_status),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .retryable   (retryable),
    .decided_by  (decided_by)
  );

  always #5 clk = ~clk;

  // true if phrase p ends at the newest byte of the window
  function automatic bit tail_match(input logic [WIN_BITS-1:0] win, input string p);
    int n;
    n = p.len();
    if (n == 0 || n > WIN_LEN) return 1'b0;
    for (int i = 0; i < n; i++) begin
      if (win[8*(WIN_LEN-n+i) +: 8] != p[i]) return 1'b0;
    end
    return 1'b1;
  endfunction

  // advance the predictor by one accepted word, queue a verdict on the last one
  task automatic classify_word(input in_word_t w);
    logic [7:0] c;
    logic [WIN_BITS-1:0] win;
    verdict_t v;
    if (w.has_char) begin
      c = w.ch;
      if (c >= 8'h41 && c <= 8'h5a) c = c + 8'h20;
      win = {c, byte_hist};
      for (int p = 0; p < NUM_TXT; p++) begin
        if (tail_match(win, phrase_txt[p])) begin
          if (p < NUM_FATAL_TXT) fatal_seen = 1'b1;
          else retry_seen = 1'b1;
        end
      end
      byte_hist = win[WIN_BITS-1:8];
    end
    if (w.last) begin
      // status rules win over anything the text said
      if (w.status == ST_400 || w.status == ST_401 || w.status == ST_403 ||
          w.status == ST_404) begin
        v.retryable = 1'b0;
        v.by = DEC_STATUS;
      end else if (w.status == ST_429 || w.status == ST_500 || w.status == ST_502 ||
                   w.status == ST_503 || w.status == ST_504 || w.status == ST_524) begin
        v.retryable = 1'b1;
        v.by = DEC_STATUS;
      end else if (fatal_seen) begin
        v.retryable = 1'b0;
        v.by = DEC_FATAL;
      end else if (retry_seen) begin
        v.retryable = 1'b1;
        v.by = DEC_RETRY;
      end else begin
        v.retryable = 1'b0;
        v.by = DEC_NONE;
      end
      verdict_q.push_back(v);
      byte_hist = '0;
      fatal_seen = 1'b0;
      retry_seen = 1'b0;
    end
  endtask

  function automatic int unsigned draw_send_gap();
    if (send_left == 0) begin
      send_quiet = !send_quiet;
      send_left = $urandom_range(10, 80);
    end
    send_left--;
    return send_quiet ? 0 : $urandom_range(0, 12);
  endfunction

  task automatic push_word(input logic [7:0] c, input logic hc, input logic lst,
                           input logic [9:0] st);
    in_word_t w;
    w.ch = c;
    w.has_char = hc;
    w.last = lst;
    w.status = st;
    w.drain = drain_next;
    w.gap = draw_send_gap();
    drain_next = 1'b0;
    word_q.push_back(w);
    words_made++;
  endtask

  // a whole message from a string; the final byte rides on the last word if asked
  task automatic push_msg(input string s, input logic [9:0] st, input bit end_on_byte);
    int n;
    n = s.len();
    for (int i = 0; i < n; i++) begin
      push_word(s[i], 1'b1, (end_on_byte && i == n - 1), st);
    end
    if (!end_on_byte || n == 0) push_word(8'($urandom_range(0, 255)), 1'b0, 1'b1, st);
  endtask

  function automatic logic [9:0] pick_status();
    logic [9:0] rule_codes [10];
    rule_codes = '{ST_400, ST_401, ST_403, ST_404, ST_429,
                   ST_500, ST_502, ST_503, ST_504, ST_524};
    case ($urandom_range(0, 3))
      0: return rule_codes[$urandom_range(0, 9)];
      1, 2: return 10'($urandom_range(0, 1023));
      default: return 10'd200;
    endcase
  endfunction

  // random message built from phrases, near misses, noise and filler
  task automatic gen_message();
    logic [7:0] body [$];
    logic [9:0] st;
    logic [7:0] b;
    string p;
    int unsigned nseg;
    int unsigned n;
    int unsigned pos;
    int unsigned cnt;
    bit tail_on_byte;
    st = pick_status();
    if (msg_cnt % 37 == 5) drain_next = 1'b1;
    msg_cnt++;
    nseg = $urandom_range(1, 4);
    repeat (nseg) begin
      p = phrase_txt[$urandom_range(0, NUM_TXT - 1)];
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: begin
          // whole phrase, random letter case
          for (int i = 0; i < p.len(); i++) begin
            b = p[i];
            if (b >= 8'h61 && b <= 8'h7a && $urandom_range(0, 1)) b = b - 8'h20;
            body.push_back(b);
          end
          // sometimes damage one byte
          if ($urandom_range(0, 5) == 0) begin
            pos = $urandom_range(0, p.len() - 1);
            body[body.size() - p.len() + pos] = 8'($urandom_range(0, 255));
          end
        end
        6: begin
          // truncated phrase
          n = $urandom_range(1, p.len() - 1);
          for (int i = 0; i < n; i++) body.push_back(p[i]);
        end
        7: begin
          repeat ($urandom_range(1, 5)) body.push_back(8'($urandom_range(0, 255)));
        end
        8: begin
          body.push_back(8'h20);
          repeat ($urandom_range(1, 8)) body.push_back(8'($urandom_range(97, 122)));
          body.push_back(8'h3a);
        end
        default: begin
          // long filler can push earlier text out of the window
          repeat ($urandom_range(15, 30)) body.push_back(8'($urandom_range(32, 126)));
        end
      endcase
    end
    cnt = body.size();
    tail_on_byte = (cnt != 0) && $urandom_range(0, 1);
    for (int i = 0; i < cnt; i++) begin
      if ($urandom_range(0, 9) == 0) push_word(8'($urandom_range(0, 255)), 1'b0, 1'b0, st);
      push_word(body[i], 1'b1, (tail_on_byte && i == cnt - 1), st);
    end
    if (!tail_on_byte) push_word(8'($urandom_range(0, 255)), 1'b0, 1'b1, st);
  endtask

  // driver: holds a word until taken, then waits out the next word's gap
  always @(posedge clk) begin : drive_words
    logic raise;
    raise = 1'b0;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        classify_word(live_w);
      end
      if (in_valid && !in_ready) begin
        raise = 1'b1;
      end else begin
        if (!staged && word_q.size() != 0) begin
          staged_w = word_q.pop_front();
          staged = 1'b1;
          gap_left = staged_w.gap;
        end
        // a drain word waits until every verdict has come back
        if (staged && !(staged_w.drain && verdict_q.size() != 0)) begin
          if (gap_left != 0) begin
            gap_left--;
          end else begin
            raise = 1'b1;
            staged = 1'b0;
            live_w = staged_w;
            ch <= staged_w.ch;
            has_char <= staged_w.has_char;
            last <= staged_w.last;
            http_status <= staged_w.status;
          end
        end
      end
      in_valid <= raise;
    end
  end

  // monitor: checks each verdict word against the oldest prediction
  always @(posedge clk) begin : watch_verdicts
    verdict_t v;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (verdict_q.size() == 0) begin
          $error("verdict word with no prediction waiting: retryable %0d decided_by %0d",
                 retryable, decided_by);
          err_cnt++;
        end else begin
          v = verdict_q.pop_front();
          if (retryable !== v.retryable) begin
            $error("retryable expected %0d got %0d", v.retryable, retryable);
            err_cnt++;
          end
          if (decided_by !== v.by) begin
            $error("decided_by expected %0d got %0d", v.by, decided_by);
            err_cnt++;
          end
        end
        if (recv_left == 0) begin
          recv_quiet = !recv_quiet;
          recv_left = $urandom_range(3, 20);
        end
        recv_left--;
        stall_left = recv_quiet ? 0 : $urandom_range(0, 12);
      end
      if (stall_left != 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    int unsigned dir_words;
    // empty message, status rule says no
    push_msg("", ST_400, 1'b0);
    // mixed case phrase, final byte on the last word
    push_msg("EoF", 10'd200, 1'b1);
    // status rule overrides a retry phrase
    push_msg("eof", ST_404, 1'b1);
    // digits phrase, status beyond the known range
    push_msg("429", 10'd1023, 1'b0);
    // top byte value on a single-word message
    push_word(8'hff, 1'b1, 1'b1, ST_524);
    // nothing matches; this one also waits for the block to drain
    drain_next = 1'b1;
    push_msg("x", 10'd0, 1'b1);
    // an empty word inside a phrase does not break it
    push_word("e", 1'b1, 1'b0, 10'd999);
    push_word("o", 1'b1, 1'b0, 10'd999);
    push_word(8'h5a, 1'b0, 1'b0, 10'd999);
    push_word("f", 1'b1, 1'b1, 10'd999);
    // a zero byte does break it
    push_word("e", 1'b1, 1'b0, 10'd300);
    push_word("o", 1'b1, 1'b0, 10'd300);
    push_word(8'h00, 1'b1, 1'b0, 10'd300);
    push_word("f", 1'b1, 1'b1, 10'd300);
    dir_words = words_made;
    while (words_made < dir_words + RANDOM_WORDS) gen_message();

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    while (word_q.size() != 0 || staged || in_valid || verdict_q.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
